// ===== rtl/core/srw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srw_pkg
// Shared types and constants for the sequence receive window.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int SEQ_W        = 32;
    localparam int HISTORY_BITS = 32;
    localparam int STATUS_W     = 2;

    localparam logic [SEQ_W-1:0] HALF_SPACE = 32'h8000_0000;
    localparam logic [SEQ_W-1:0] HIST_MASK  =
        SEQ_W'((64'd1 << HISTORY_BITS) - 64'd1);

    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_OLD   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 72;

    typedef struct packed {
        logic [SEQ_W-1:0]    history_bits;
        logic [SEQ_W-1:0]    latest_sequence;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/sequence_receive_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_receive_window
// Sliding-window replay check for received 32-bit packet sequence numbers.
// ----------------------------------------------------------------------------
// path: an accepted item enters the input register, then classify and
//   window update write the result into the result register
// throughput: one item per cycle while m_tready does not hold back a result;
//   the window state updates in the same cycle the item leaves the input register
// reset: aresetn low clears the window, the seen flag and both stage valids
module sequence_receive_window (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] sequence_req
    input  wire logic [srw_pkg::TDATA_IN_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] status, [33:2] latest_sequence, [65:34] history_bits, [71:66] zero
    output logic [srw_pkg::TDATA_OUT_W-1:0]        m_tdata
);

    logic                      in_valid_reg;
    logic [srw_pkg::SEQ_W-1:0] in_seq_reg;
    logic                      out_valid_reg;
    srw_pkg::result_t          out_res_reg;
    srw_pkg::result_t          res;
    logic                      advance;

    // the input stage moves on when the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    srw_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_valid_reg && advance),
        .seq     (in_seq_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_seq_reg <= s_tdata[srw_pkg::SEQ_W-1:0];
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg};

endmodule
`default_nettype wire

// ===== rtl/core/srw_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srw_window
// Window state and the per-item classify and update logic.
// ----------------------------------------------------------------------------
module srw_window (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step_en,
    input  wire logic [srw_pkg::SEQ_W-1:0]    seq,
    output srw_pkg::result_t                  res
);

    logic [srw_pkg::SEQ_W-1:0] newest_reg, newest_next;
    logic [srw_pkg::SEQ_W-1:0] map_reg, map_next;
    logic                      seen_reg, seen_next;

    logic [srw_pkg::SEQ_W-1:0] ahead;
    logic [srw_pkg::SEQ_W-1:0] behind;
    logic [srw_pkg::SEQ_W-1:0] old_bit;
    logic [srw_pkg::STATUS_W-1:0] status;

    assign ahead  = seq - newest_reg;
    assign behind = newest_reg - seq;

    always_comb begin
        newest_next = newest_reg;
        map_next    = map_reg;
        seen_next   = seen_reg;
        status      = srw_pkg::ST_ACCEPTED;
        // behind is only used as a bit index once it is known to be 1..HISTORY_BITS
        old_bit     = srw_pkg::SEQ_W'(1) << behind[4:0] - 5'd1;
        if (seq == '0) begin
            status = srw_pkg::ST_INVALID;
        end else if (!seen_reg) begin
            newest_next = seq;
            map_next    = '0;
            seen_next   = 1'b1;
        end else if (ahead != '0 && ahead < srw_pkg::HALF_SPACE) begin
            if (ahead > srw_pkg::SEQ_W'(srw_pkg::HISTORY_BITS)) begin
                map_next = '0;
            end else begin
                // ahead is 1..32 here, a shift by 32 clears the map
                map_next = ((map_reg << ahead[5:0])
                           | (srw_pkg::SEQ_W'(1) << (ahead[5:0] - 6'd1)))
                           & srw_pkg::HIST_MASK;
            end
            newest_next = seq;
        end else if (behind == '0) begin
            status = srw_pkg::ST_DUPLICATE;
        end else if (behind > srw_pkg::SEQ_W'(srw_pkg::HISTORY_BITS)) begin
            status = srw_pkg::ST_TOO_OLD;
        end else if ((map_reg & old_bit) != '0) begin
            status = srw_pkg::ST_DUPLICATE;
        end else begin
            map_next = map_reg | old_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg <= '0;
            map_reg    <= '0;
            seen_reg   <= 1'b0;
        end else if (step_en) begin
            newest_reg <= newest_next;
            map_reg    <= map_next;
            seen_reg   <= seen_next;
        end
    end

    assign res.status          = status;
    assign res.latest_sequence = newest_next;
    assign res.history_bits    = map_next;

endmodule
`default_nettype wire

// ===== test/sequence_receive_window_checker.sv =====
// ----------------------------------------------------------------------------
// sequence_receive_window_checker
// Watches both stream channels of the receive window. Every accepted
// sequence number runs through a local copy of the window (newest sequence,
// history map, seeded flag) to form the expected result. Every accepted
// result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module sequence_receive_window_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // [31:0] sequence_req
    input  wire logic [srw_pkg::TDATA_IN_W-1:0]    s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] status, [33:2] latest_sequence, [65:34] history_bits, [71:66] zero
    input  wire logic [srw_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output int                                     fail_count,
    output int                                     pending
);
    import srw_pkg::*;

    logic [SEQ_W-1:0] window_head;
    logic [SEQ_W-1:0] window_map;
    logic             window_seeded;

    result_t expected_windows [$];
    int      mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string field, input logic [SEQ_W-1:0] got,
                                   input logic [SEQ_W-1:0] want);
        $display("mismatch in %s: got %h, expected %h", field, got, want);
        mismatches++;
    endtask

    // classify one sequence number and move the window as the block must
    task automatic slide_window(input logic [SEQ_W-1:0] seq, output result_t res);
        logic [SEQ_W-1:0]    ahead;
        logic [SEQ_W-1:0]    behind;
        logic [SEQ_W-1:0]    mark;
        logic [STATUS_W-1:0] verdict;
        ahead  = seq - window_head;
        behind = window_head - seq;
        if (seq == '0) begin
            verdict = ST_INVALID;
        end else if (!window_seeded) begin
            window_head   = seq;
            window_map    = '0;
            window_seeded = 1'b1;
            verdict       = ST_ACCEPTED;
        end else if (ahead != '0 && ahead < HALF_SPACE) begin
            if (ahead > SEQ_W'(HISTORY_BITS)) begin
                window_map = '0;
            end else begin
                // a shift by the full width leaves zero
                window_map = ((window_map << ahead) | (SEQ_W'(1) << (ahead - 1))) & HIST_MASK;
            end
            window_head = seq;
            verdict     = ST_ACCEPTED;
        end else if (behind == '0) begin
            verdict = ST_DUPLICATE;
        end else if (behind > SEQ_W'(HISTORY_BITS)) begin
            verdict = ST_TOO_OLD;
        end else begin
            mark = SEQ_W'(1) << (behind - 1);
            if ((window_map & mark) != '0) begin
                verdict = ST_DUPLICATE;
            end else begin
                window_map = window_map | mark;
                verdict    = ST_ACCEPTED;
            end
        end
        res.status          = verdict;
        res.latest_sequence = window_head;
        res.history_bits    = window_map;
    endtask

    always @(posedge aclk) begin
        result_t predicted;
        result_t observed;
        result_t oldest;
        if (!aresetn) begin
            window_head   = '0;
            window_map    = '0;
            window_seeded = 1'b0;
            expected_windows.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                slide_window(s_tdata[SEQ_W-1:0], predicted);
                expected_windows.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                observed = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_windows.size() == 0) begin
                    report_mismatch("unexpected result item", SEQ_W'(observed.status),
                                    observed.latest_sequence);
                end else begin
                    oldest = expected_windows.pop_front();
                    if (observed.status != oldest.status)
                        report_mismatch("status", SEQ_W'(observed.status),
                                        SEQ_W'(oldest.status));
                    if (observed.latest_sequence != oldest.latest_sequence)
                        report_mismatch("latest_sequence", observed.latest_sequence,
                                        oldest.latest_sequence);
                    if (observed.history_bits != oldest.history_bits)
                        report_mismatch("history_bits", observed.history_bits,
                                        oldest.history_bits);
                    if (m_tdata[TDATA_OUT_W-1:$bits(result_t)] != '0)
                        report_mismatch("padding", SEQ_W'(m_tdata[TDATA_OUT_W-1:$bits(result_t)]),
                                        '0);
                end
            end
        end
        pending <= expected_windows.size();
    end

endmodule

// ===== test/sequence_receive_window_tb.sv =====
// ----------------------------------------------------------------------------
// sequence_receive_window_tb
// Drives received sequence numbers into the receive window: a directed run
// over seeding, wraparound, window edges and the half-space boundary, then
// random traffic mostly near the window head, across phases of sender idling
// and receiver back-pressure. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module sequence_receive_window_tb;
    import srw_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_DIRECTED  = 21;

    localparam logic [SEQ_W-1:0] DIRECTED_SEQS [NUM_DIRECTED] = '{
        32'h0000_0000,  // zero before anything arrived
        32'hFFFF_FFF0,  // seeds the window
        32'hFFFF_FFF0,  // same as newest
        32'hFFFF_FFF1,  // newer by one
        32'h0000_0011,  // newer by the full history width, across the wrap
        32'hFFFF_FFF1,  // oldest slot, already marked
        32'hFFFF_FFF2,  // inside the window, not yet marked
        32'hFFFF_FFF0,  // one past the window
        32'hFFFF_FFF2,  // now marked
        32'h0000_0032,  // newer by one past the width, map clears
        32'h8000_0031,  // largest step that still counts as newer
        32'h0000_0031,  // exactly half the space away counts as older
        32'h0000_0000,  // zero with a live window
        32'hFFFF_FFFF,
        32'h0000_0001,  // newer across the wrap
        32'hFFFF_FFFF,
        32'hFFFF_FFFC,
        32'h0000_0001,
        32'h0000_0020,
        32'h0000_0001,
        32'h8000_0000
    };

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_tdata;

    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               send_idle   = 0;
    int               recv_stall  = 0;
    logic [SEQ_W-1:0] head_guess  = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    sequence_receive_window dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sequence_receive_window_checker window_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_sequence(input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] ahead;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seq;
        do @(posedge aclk); while (!s_tready);
        // follow the window head so that random items land near it
        ahead = seq - head_guess;
        if (seq != '0 && ahead != '0 && ahead < HALF_SPACE)
            head_guess = seq;
    endtask

    task automatic send_random_sequence();
        int               pick;
        logic [SEQ_W-1:0] seq;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            seq = head_guess + SEQ_W'($urandom_range(0, 80)) - SEQ_W'(40);
        else if (pick < 78)
            seq = head_guess + SEQ_W'($urandom_range(30, 34));
        else if (pick < 82)
            seq = head_guess - SEQ_W'($urandom_range(30, 34));
        else if (pick < 86)
            seq = '0;
        else if (pick < 92)
            seq = head_guess + HALF_SPACE + SEQ_W'($urandom_range(0, 2)) - SEQ_W'(1);
        else
            seq = $urandom();
        send_sequence(seq);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_SEQS[i])
            send_sequence(DIRECTED_SEQS[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 73; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 73; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_sequence();
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
